@@ rtl/core/lag_pkg.sv @@
// ----------------------------------------------------------------------------
// lag_pkg - shared types and constants for the life automaton grid
// Grid geometry, request codes, controller states, command/status words and
// the B3/S23 next-generation function for one grid row.
// ----------------------------------------------------------------------------
package lag_pkg;

	localparam int GRID_SIZE = 256;
	localparam int ADDR_W    = $clog2(GRID_SIZE);
	localparam int COORD_W   = 8;
	localparam int CNT_W     = 4;

	localparam logic [CNT_W-1:0] BIRTH_COUNT = CNT_W'(3);
	localparam logic [CNT_W-1:0] SURVIVE_MIN = CNT_W'(2);

	typedef logic [GRID_SIZE-1:0] row_t;
	typedef logic [ADDR_W-1:0]    addr_t;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_READ    = 2'd1,
		REQ_ADVANCE = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_e;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WR,
		ST_CLR,
		ST_ADV_INIT,
		ST_ADV_CUR,
		ST_ADV_RD,
		ST_ADV_WR,
		ST_RD,
		ST_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic  capture;      // latch request word
		logic  rd_req;       // read cell and mark rows at request row
		logic  adv_rd_cur;   // read cell row at sweep row
		logic  adv_rd_next;  // read cell row below, mark row at sweep row
		logic  load_cur;     // sweep: take current row
		logic  adv_write;    // sweep: write new generation row
		logic  wr_cell;      // merge single-cell write
		logic  clear;        // drop both grids
		logic  load_out;     // load response register
		logic  first;        // sweep row is top row
		logic  last;         // sweep row is bottom row
		addr_t row;          // sweep row
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} stat_t;

	// B3/S23 on one row; cells beyond the edges are dead
	function automatic row_t next_gen(row_t prev, row_t cur, row_t nxt);
		logic [GRID_SIZE+1:0] p;
		logic [GRID_SIZE+1:0] c;
		logic [GRID_SIZE+1:0] n;
		logic [CNT_W-1:0]     cnt;
		row_t                 res;
		p = {1'b0, prev, 1'b0};
		c = {1'b0, cur,  1'b0};
		n = {1'b0, nxt,  1'b0};
		res = '0;
		for (int i = 0; i < GRID_SIZE; i++) begin
			cnt = CNT_W'(p[i]) + CNT_W'(p[i+1]) + CNT_W'(p[i+2])
			    + CNT_W'(c[i]) + CNT_W'(c[i+2])
			    + CNT_W'(n[i]) + CNT_W'(n[i+1]) + CNT_W'(n[i+2]);
			res[i] = (cnt == BIRTH_COUNT) || (cur[i] && (cnt == SURVIVE_MIN));
		end
		return res;
	endfunction

endpackage

@@ rtl/core/lag_chan_if.sv @@
// ----------------------------------------------------------------------------
// lag_chan_if - request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lag_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic [lag_pkg::COORD_W-1:0]  row;
	logic [lag_pkg::COORD_W-1:0]  col;
	logic                         cell_value;

	modport source (output valid, req_type, row, col, cell_value, input ready);
	modport sink   (input valid, req_type, row, col, cell_value, output ready);
endinterface

interface lag_rsp_if;
	logic valid;
	logic ready;
	logic cell_alive;
	logic ever_alive;

	modport source (output valid, cell_alive, ever_alive, input ready);
	modport sink   (input valid, cell_alive, ever_alive, output ready);
endinterface

@@ rtl/core/lag_ctrl.sv @@
// ----------------------------------------------------------------------------
// lag_ctrl - request sequencer
// Steps each request through its memory reads and writes, sweeps the grid
// row by row for an advance, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lag_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            ready,
	input  lag_pkg::req_e   req_type,
	input  lag_pkg::stat_t  stat,
	output lag_pkg::cmd_t   cmd
);
	import lag_pkg::*;

	state_t state_q;
	state_t state_nxt;
	addr_t  row_q;
	logic   accept;
	logic   last;

	assign ready  = (state_q == ST_IDLE);
	assign accept = valid && ready;
	assign last   = (row_q == ADDR_W'(GRID_SIZE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				row_q <= '0;
			end else if (state_q == ST_ADV_WR && !last) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_WRITE:   state_nxt = ST_WR_RD;
						REQ_READ:    state_nxt = ST_RD;
						REQ_ADVANCE: state_nxt = ST_ADV_INIT;
						REQ_CLEAR:   state_nxt = ST_CLR;
						default:     state_nxt = ST_RD;
					endcase
				end
			end
			ST_WR_RD:    state_nxt = ST_WR_WR;
			ST_WR_WR:    state_nxt = ST_RD;
			ST_CLR:      state_nxt = ST_RD;
			ST_ADV_INIT: state_nxt = ST_ADV_CUR;
			ST_ADV_CUR:  state_nxt = ST_ADV_WR;
			ST_ADV_RD:   state_nxt = ST_ADV_WR;
			ST_ADV_WR:   state_nxt = last ? ST_RD : ST_ADV_RD;
			ST_RD:       state_nxt = ST_RESP;
			ST_RESP: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.row     = row_q;
		cmd.first   = (row_q == '0);
		cmd.last    = last;
		case (state_q)
			ST_WR_RD:    cmd.rd_req = 1'b1;
			ST_WR_WR:    cmd.wr_cell = 1'b1;
			ST_CLR:      cmd.clear = 1'b1;
			ST_ADV_INIT: cmd.adv_rd_cur = 1'b1;
			ST_ADV_CUR: begin
				cmd.load_cur    = 1'b1;
				cmd.adv_rd_next = 1'b1;
			end
			ST_ADV_RD:   cmd.adv_rd_next = 1'b1;
			ST_ADV_WR:   cmd.adv_write = 1'b1;
			ST_RD:       cmd.rd_req = 1'b1;
			ST_RESP:     cmd.load_out = stat.out_free;
			default:     cmd.capture = accept;
		endcase
	end

endmodule

@@ rtl/core/lag_dp.sv @@
// ----------------------------------------------------------------------------
// lag_dp - grid storage and row datapath
// Row-wide cell and mark memories with per-row valid bits, the three-row
// window for the generation sweep, and the response register.
// ----------------------------------------------------------------------------
module lag_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lag_pkg::cmd_t                cmd,
	output lag_pkg::stat_t               stat,
	input  logic [lag_pkg::COORD_W-1:0]  req_row,
	input  logic [lag_pkg::COORD_W-1:0]  req_col,
	input  logic                         req_cell_value,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         cell_alive,
	output logic                         ever_alive
);
	import lag_pkg::*;

	// request word
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic               val_q;

	// storage
	row_t                 cell_mem [GRID_SIZE];
	row_t                 mark_mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] cell_vld_q;
	logic [GRID_SIZE-1:0] mark_vld_q;
	row_t                 cell_rd_q;
	row_t                 mark_rd_q;
	logic                 cell_rv_q;
	logic                 mark_rv_q;

	// sweep window
	row_t cur_q;
	row_t prev_q;

	logic out_valid_q;
	logic cell_alive_q;
	logic ever_alive_q;

	logic  on_grid;
	addr_t req_addr;
	addr_t col_idx;
	addr_t nxt_addr;
	addr_t cell_ra;
	addr_t cell_wa;
	addr_t mark_ra;
	logic  cell_re;
	logic  cell_we;
	logic  mark_re;
	row_t  cell_wd;
	row_t  cell_m;
	row_t  mark_m;
	row_t  merged;
	row_t  new_row;

	assign on_grid  = (32'(row_q) < GRID_SIZE) && (32'(col_q) < GRID_SIZE);
	assign req_addr = ADDR_W'(row_q);
	assign col_idx  = ADDR_W'(col_q);
	assign nxt_addr = cmd.row + 1'b1;

	assign cell_m = cell_rv_q ? cell_rd_q : '0;
	assign mark_m = mark_rv_q ? mark_rd_q : '0;

	assign cell_re = cmd.rd_req || cmd.adv_rd_cur || (cmd.adv_rd_next && !cmd.last);
	assign cell_ra = cmd.rd_req ? req_addr : (cmd.adv_rd_cur ? cmd.row : nxt_addr);
	assign mark_re = cmd.rd_req || cmd.adv_rd_next;
	assign mark_ra = cmd.rd_req ? req_addr : cmd.row;

	assign new_row = next_gen(cmd.first ? '0 : prev_q, cur_q, cmd.last ? '0 : cell_m);

	always_comb begin
		merged          = cell_m;
		merged[col_idx] = val_q;
	end

	assign cell_we = (cmd.wr_cell && on_grid) || cmd.adv_write;
	assign cell_wa = cmd.adv_write ? cmd.row : req_addr;
	assign cell_wd = cmd.adv_write ? new_row : merged;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= req_row;
			col_q <= req_col;
			val_q <= req_cell_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		if (cell_re) begin
			cell_rd_q <= cell_mem[cell_ra];
			cell_rv_q <= cell_vld_q[cell_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv_write) begin
			mark_mem[cmd.row] <= mark_m | new_row;
		end
		if (mark_re) begin
			mark_rd_q <= mark_mem[mark_ra];
			mark_rv_q <= mark_vld_q[mark_ra];
		end
	end

	// a row never written since reset or clear reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= '0;
			mark_vld_q <= '0;
		end else if (cmd.clear) begin
			cell_vld_q <= '0;
			mark_vld_q <= '0;
		end else begin
			if (cell_we) begin
				cell_vld_q[cell_wa] <= 1'b1;
			end
			if (cmd.adv_write) begin
				mark_vld_q[cmd.row] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_cur) begin
			cur_q <= cell_m;
		end else if (cmd.adv_write) begin
			prev_q <= cur_q;
			cur_q  <= cell_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_alive_q <= on_grid && cell_m[col_idx];
			ever_alive_q <= on_grid && mark_m[col_idx];
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign cell_alive    = cell_alive_q;
	assign ever_alive    = ever_alive_q;

endmodule

@@ rtl/core/life_automaton_grid_top.sv @@
// ----------------------------------------------------------------------------
// life_automaton_grid_top - B3/S23 cellular automaton on a square grid
// Holds the cell grid and the ever-alive marks; serves write, read, advance
// and clear requests, one response word per request word.
// ----------------------------------------------------------------------------
// Use:
//  - req channel: one word per request (req_type, row, col, cell_value).
//    The word is taken when req.valid and req.ready are both high.
//  - rsp channel: one word per request, in order: the addressed cell's state
//    and ever-alive mark after the request; zero for an address off the grid.
//  - The row sweep handles one row at a time: read the row below plus the mark
//    row, then write back. The next request is taken the cycle after the
//    response is loaded.
//  - Cell and mark memories are one row wide; each row has a valid bit, so
//    reset and clear drop both grids at once with no clearing pass.
//  - A stalled response sits in the output register; the block finishes the
//    next request up to its response and waits there until the slot frees.
// ----------------------------------------------------------------------------
module life_automaton_grid_top (
	input  logic clk,
	input  logic arst_n,
	lag_req_if.sink   req,
	lag_rsp_if.source rsp
);
	import lag_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// request sequencer
	lag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (req.valid),
		.ready    (req.ready),
		.req_type (req_e'(req.req_type)),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, sweep window and response register
	lag_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_row        (req.row),
		.req_col        (req.col),
		.req_cell_value (req.cell_value),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.cell_alive     (rsp.cell_alive),
		.ever_alive     (rsp.ever_alive)
	);

`ifndef ASSERT_OFF
	// a taken word moves the sequencer out of idle, so it blocks the next word
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken on consecutive cycles");

	// the response register is never overwritten while its word is unread
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && rsp.valid) |-> rsp.ready)
		else $error("response overwritten before it was taken");

	// at most one kind of grid update in any cycle
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.adv_write, cmd.wr_cell}))
		else $error("conflicting grid updates");
`endif

endmodule

@@ tb/sv/lag_grid_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lag_grid_checker - scoreboard for the life automaton grid
// Keeps its own copy of both grids, applies every accepted request word to it
// and checks each response word, in order, against the predicted cell report.
// ----------------------------------------------------------------------------
module lag_grid_checker (
	input  logic        clk,
	input  logic        arst_n,
	lag_req_if          req,
	lag_rsp_if          rsp,
	output int unsigned errors,
	output int unsigned outstanding
);

	import lag_pkg::*;

	typedef struct {
		req_e                kind;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
		logic                cell_alive;
		logic                ever_alive;
	} cell_report_t;

	row_t         live_rows [GRID_SIZE];
	row_t         mark_rows [GRID_SIZE];
	cell_report_t reports_due [$];

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	function automatic void wipe_grids();
		for (int r = 0; r < GRID_SIZE; r++) begin
			live_rows[r] = '0;
			mark_rows[r] = '0;
		end
	endfunction

	// one generation, row by row; bit c of a row is column c
	// neighbour counts are kept bit-sliced, four planes wide
	function automatic void step_generation();
		row_t above_old;
		row_t here_old;
		row_t below;
		row_t fresh;
		row_t nb [8];
		row_t s0, s1, s2, s3;
		row_t cy, t;
		above_old = '0;
		for (int r = 0; r < GRID_SIZE; r++) begin
			here_old = live_rows[r];
			below    = (r + 1 < GRID_SIZE) ? live_rows[r+1] : '0;
			nb = '{above_old << 1, above_old, above_old >> 1,
			       here_old  << 1,            here_old  >> 1,
			       below     << 1, below,     below     >> 1};
			s0 = '0; s1 = '0; s2 = '0; s3 = '0;
			for (int k = 0; k < 8; k++) begin
				cy = nb[k];
				t  = s0 & cy; s0 = s0 ^ cy; cy = t;
				t  = s1 & cy; s1 = s1 ^ cy; cy = t;
				t  = s2 & cy; s2 = s2 ^ cy; cy = t;
				s3 = s3 | cy;
			end
			// exactly three: birth or survival; exactly two: survival only
			fresh = (s0 & s1 & ~s2 & ~s3) | (here_old & ~s0 & s1 & ~s2 & ~s3);
			live_rows[r] = fresh;
			mark_rows[r] = mark_rows[r] | fresh;
			above_old    = here_old;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cell_report_t fresh_due;
		cell_report_t oldest;
		logic         on_grid;
		if (!arst_n) begin
			wipe_grids();
			reports_due.delete();
			outstanding = 0;
		end else begin
			if (req.valid && req.ready) begin
				fresh_due.kind = req_e'(req.req_type);
				fresh_due.row  = req.row;
				fresh_due.col  = req.col;
				on_grid = (int'(req.row) < GRID_SIZE) && (int'(req.col) < GRID_SIZE);
				case (fresh_due.kind)
					REQ_WRITE: begin
						if (on_grid)
							live_rows[req.row][req.col] = req.cell_value;
					end
					REQ_ADVANCE: step_generation();
					REQ_CLEAR:   wipe_grids();
					default: ;
				endcase
				fresh_due.cell_alive = on_grid ? live_rows[req.row][req.col] : 1'b0;
				fresh_due.ever_alive = on_grid ? mark_rows[req.row][req.col] : 1'b0;
				reports_due.push_back(fresh_due);
			end
			if (rsp.valid && rsp.ready) begin
				if (reports_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: response word with no request outstanding", $realtime);
					errors++;
				end else begin
					oldest = reports_due.pop_front();
					if (rsp.cell_alive !== oldest.cell_alive
					    || rsp.ever_alive !== oldest.ever_alive) begin
						if (errors < 10)
							$display("%0t: %s r=%0d c=%0d: expected alive=%0b ever=%0b, got alive=%0b ever=%0b",
							         $realtime, oldest.kind.name(), oldest.row, oldest.col,
							         oldest.cell_alive, oldest.ever_alive,
							         rsp.cell_alive, rsp.ever_alive);
						errors++;
					end
				end
			end
			outstanding = reports_due.size();
		end
	end

endmodule

@@ tb/sv/life_automaton_grid_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_grid_top_tb - testbench for the life automaton grid
// Directed words on edges and corners, then random small patterns that are
// written, advanced and read back, mixed with random noise words. Both
// channels stall at random; the checker beside the block scores every word.
// ----------------------------------------------------------------------------
module life_automaton_grid_top_tb;

	import lag_pkg::*;

	localparam int RANDOM_WORDS = 1900;
	localparam int FIRST_WORDS  = 25;

	logic        clk;
	logic        arst_n;
	int unsigned err_count;
	int unsigned due_count;
	int unsigned words_sent;
	bit          calm;      // no idling on either side while set

	lag_req_if req_ch ();
	lag_rsp_if rsp_ch ();

	life_automaton_grid_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lag_grid_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (err_count),
		.outstanding (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// guard: worst case is far below this even if every word were an advance
	initial begin
		#8000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// response side: stall with a chance of about 21 in a hundred, never while calm
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 21);
		end
	end

	// coordinate within a small window round base, clamped to the grid
	function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base);
		int v;
		v = int'(base) + int'($urandom_range(0, 7)) - 1;
		if (v < 0)
			v = 0;
		if (v > GRID_SIZE - 1)
			v = GRID_SIZE - 1;
		return v[COORD_W-1:0];
	endfunction

	// offer one request word; returns once it has been taken
	// valid stays high into the next call unless that call idles first
	task automatic send_word(input req_e kind, input logic [COORD_W-1:0] r,
	                         input logic [COORD_W-1:0] c, input logic v);
		while (!calm && $urandom_range(0, 99) < 21) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.row        <= r;
		req_ch.col        <= c;
		req_ch.cell_value <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	initial begin
		logic [COORD_W-1:0] r0;
		logic [COORD_W-1:0] c0;
		int                 fills;
		int                 gens;
		int                 looks;
		int                 roll;
		req_e               kind;

		words_sent = 0;
		calm       = 1'b0;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_READ;
		req_ch.row        <= '0;
		req_ch.col        <= '0;
		req_ch.cell_value <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		send_word(REQ_READ,    8'd0,   8'd0,   1'b0);  // grid empty after reset
		send_word(REQ_WRITE,   8'd0,   8'd0,   1'b1);
		send_word(REQ_READ,    8'd0,   8'd0,   1'b0);  // alive, write leaves mark clear
		send_word(REQ_WRITE,   8'd255, 8'd255, 1'b1);
		send_word(REQ_WRITE,   8'd0,   8'd255, 1'b1);
		send_word(REQ_WRITE,   8'd255, 8'd0,   1'b1);
		send_word(REQ_ADVANCE, 8'd255, 8'd255, 1'b0);  // lone corners die
		send_word(REQ_READ,    8'd0,   8'd0,   1'b1);
		// blinker lying on the top edge: half of it is beyond the edge
		send_word(REQ_WRITE,   8'd0,   8'd1,   1'b1);
		send_word(REQ_WRITE,   8'd0,   8'd2,   1'b1);
		send_word(REQ_WRITE,   8'd0,   8'd3,   1'b1);
		send_word(REQ_ADVANCE, 8'd0,   8'd2,   1'b1);  // cell_value ignored
		send_word(REQ_READ,    8'd1,   8'd2,   1'b0);  // born below
		send_word(REQ_READ,    8'd0,   8'd1,   1'b0);  // dead, and its mark is clear
		send_word(REQ_WRITE,   8'd1,   8'd2,   1'b0);  // kill: mark survives
		// still block in the bottom right corner
		send_word(REQ_WRITE,   8'd254, 8'd254, 1'b1);
		send_word(REQ_WRITE,   8'd254, 8'd255, 1'b1);
		send_word(REQ_WRITE,   8'd255, 8'd254, 1'b1);
		send_word(REQ_WRITE,   8'd255, 8'd255, 1'b1);
		send_word(REQ_ADVANCE, 8'd255, 8'd255, 1'b0);
		send_word(REQ_READ,    8'd254, 8'd254, 1'b1);
		send_word(REQ_CLEAR,   8'd255, 8'd255, 1'b1);  // both grids dropped
		send_word(REQ_READ,    8'd1,   8'd2,   1'b0);
		send_word(REQ_ADVANCE, 8'd128, 8'd127, 1'b1);  // advance of an empty grid
		send_word(REQ_WRITE,   8'd127, 8'd128, 1'b0);

		// --- random part ---
		while (words_sent < FIRST_WORDS + RANDOM_WORDS) begin
			calm = (words_sent >= 900) && (words_sent < 1150);
			if ($urandom_range(0, 99) < 70) begin
				// small pattern: seed a window, advance a few times, look round it
				if ($urandom_range(0, 99) < 30)
					r0 = $urandom_range(0, 1) ? 8'd0 : 8'd250;
				else
					r0 = COORD_W'($urandom_range(0, 255));
				if ($urandom_range(0, 99) < 30)
					c0 = $urandom_range(0, 1) ? 8'd0 : 8'd250;
				else
					c0 = COORD_W'($urandom_range(0, 255));
				fills = $urandom_range(3, 12);
				repeat (fills)
					send_word(REQ_WRITE, near_coord(r0), near_coord(c0),
					          $urandom_range(0, 99) < 80);
				gens = $urandom_range(1, 3);
				repeat (gens) begin
					send_word(REQ_ADVANCE, near_coord(r0), near_coord(c0),
					          1'($urandom_range(0, 1)));
					looks = $urandom_range(2, 5);
					repeat (looks)
						send_word(REQ_READ, near_coord(r0), near_coord(c0),
						          1'($urandom_range(0, 1)));
				end
			end else begin
				// noise word anywhere on the grid
				roll = $urandom_range(0, 99);
				if (roll < 40)
					kind = REQ_WRITE;
				else if (roll < 85)
					kind = REQ_READ;
				else if (roll < 93)
					kind = REQ_ADVANCE;
				else
					kind = REQ_CLEAR;
				send_word(kind, COORD_W'($urandom_range(0, 255)),
				          COORD_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		// drain: wait for every response, then idle before the final check
		while (due_count != 0)
			@(posedge clk);
		repeat (2 * GRID_SIZE + 8) @(posedge clk);

		if (err_count == 0 && due_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/lag_pkg.sv
rtl/core/lag_chan_if.sv
rtl/core/lag_ctrl.sv
rtl/core/lag_dp.sv
rtl/core/life_automaton_grid_top.sv
tb/sv/lag_grid_checker.sv
tb/sv/life_automaton_grid_top_tb.sv
